// File: src/msh_pkg.sv
// Package with shared types, constants and round tables of the MD5/SHA-1 engine.
`timescale 1ns / 1ps

package msh_pkg;

	localparam int COUNT_WIDTH_DEF = 61;

	localparam logic ALG_MD5  = 1'b0;
	localparam logic ALG_SHA1 = 1'b1;

	localparam logic [31:0] INIT_H0 = 32'h67452301;
	localparam logic [31:0] INIT_H1 = 32'hefcdab89;
	localparam logic [31:0] INIT_H2 = 32'h98badcfe;
	localparam logic [31:0] INIT_H3 = 32'h10325476;
	localparam logic [31:0] INIT_H4 = 32'hc3d2e1f0;

	localparam logic [31:0] SHA1_K0 = 32'h5a827999;
	localparam logic [31:0] SHA1_K1 = 32'h6ed9eba1;
	localparam logic [31:0] SHA1_K2 = 32'h8f1bbcdc;
	localparam logic [31:0] SHA1_K3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [6:0] MD5_LAST_ROUND  = 7'd63;
	localparam logic [6:0] SHA1_LAST_ROUND = 7'd79;
	localparam logic [2:0] MD5_LAST_WORD   = 3'd3;
	localparam logic [2:0] SHA1_LAST_WORD  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		RET_IDLE,
		RET_PAD,
		RET_LEN,
		RET_OUT
	} ret_t;

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] k);
		logic [4:0] s;
		case ({k[5:4], k[1:0]})
			4'd0: s = 5'd7;
			4'd1: s = 5'd12;
			4'd2: s = 5'd17;
			4'd3: s = 5'd22;
			4'd4: s = 5'd5;
			4'd5: s = 5'd9;
			4'd6: s = 5'd14;
			4'd7: s = 5'd20;
			4'd8: s = 5'd4;
			4'd9: s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] md5_k(input logic [5:0] k);
		logic [31:0] c;
		case (k)
			6'd0: c = 32'hd76aa478;
			6'd1: c = 32'he8c7b756;
			6'd2: c = 32'h242070db;
			6'd3: c = 32'hc1bdceee;
			6'd4: c = 32'hf57c0faf;
			6'd5: c = 32'h4787c62a;
			6'd6: c = 32'ha8304613;
			6'd7: c = 32'hfd469501;
			6'd8: c = 32'h698098d8;
			6'd9: c = 32'h8b44f7af;
			6'd10: c = 32'hffff5bb1;
			6'd11: c = 32'h895cd7be;
			6'd12: c = 32'h6b901122;
			6'd13: c = 32'hfd987193;
			6'd14: c = 32'ha679438e;
			6'd15: c = 32'h49b40821;
			6'd16: c = 32'hf61e2562;
			6'd17: c = 32'hc040b340;
			6'd18: c = 32'h265e5a51;
			6'd19: c = 32'he9b6c7aa;
			6'd20: c = 32'hd62f105d;
			6'd21: c = 32'h02441453;
			6'd22: c = 32'hd8a1e681;
			6'd23: c = 32'he7d3fbc8;
			6'd24: c = 32'h21e1cde6;
			6'd25: c = 32'hc33707d6;
			6'd26: c = 32'hf4d50d87;
			6'd27: c = 32'h455a14ed;
			6'd28: c = 32'ha9e3e905;
			6'd29: c = 32'hfcefa3f8;
			6'd30: c = 32'h676f02d9;
			6'd31: c = 32'h8d2a4c8a;
			6'd32: c = 32'hfffa3942;
			6'd33: c = 32'h8771f681;
			6'd34: c = 32'h6d9d6122;
			6'd35: c = 32'hfde5380c;
			6'd36: c = 32'ha4beea44;
			6'd37: c = 32'h4bdecfa9;
			6'd38: c = 32'hf6bb4b60;
			6'd39: c = 32'hbebfbc70;
			6'd40: c = 32'h289b7ec6;
			6'd41: c = 32'heaa127fa;
			6'd42: c = 32'hd4ef3085;
			6'd43: c = 32'h04881d05;
			6'd44: c = 32'hd9d4d039;
			6'd45: c = 32'he6db99e5;
			6'd46: c = 32'h1fa27cf8;
			6'd47: c = 32'hc4ac5665;
			6'd48: c = 32'hf4292244;
			6'd49: c = 32'h432aff97;
			6'd50: c = 32'hab9423a7;
			6'd51: c = 32'hfc93a039;
			6'd52: c = 32'h655b59c3;
			6'd53: c = 32'h8f0ccc92;
			6'd54: c = 32'hffeff47d;
			6'd55: c = 32'h85845dd1;
			6'd56: c = 32'h6fa87e4f;
			6'd57: c = 32'hfe2ce6e0;
			6'd58: c = 32'ha3014314;
			6'd59: c = 32'h4e0811a1;
			6'd60: c = 32'hf7537e82;
			6'd61: c = 32'hbd3af235;
			6'd62: c = 32'h2ad7d2bb;
			default: c = 32'heb86d391;
		endcase
		return c;
	endfunction

endpackage

// File: src/md5_sha1_hash_engine.sv
// Top level of the MD5/SHA-1 streaming hash engine.
`timescale 1ns / 1ps

// The slave stream takes one request per message byte: tdata holds the byte, tuser[0] says
// whether the byte is present and tlast marks the final request of a message. A request with
// tuser[0] low and tlast low does nothing; one with tuser[0] low and tlast high ends the
// message without adding a byte, which also hashes an empty message.
// The configuration channel writes the algorithm bit (0 MD5, 1 SHA-1) while the engine idles.
// The byte that fills a 64-byte block starts a compression on the single round unit: a load
// state, the round state for each round (64 for MD5, 80 for SHA-1) and a fold state, during
// all of which tready is low. On tlast the engine pads, runs one or two further compressions
// and then presents the 4 or 5 digest words on the master stream; tuser carries the word
// index and tlast the final word. The sustained byte rate is set by the round unit.
// A stalled receiver simply holds the current digest word; no new request is taken until the
// final word is accepted. Reset returns the chaining words to their initial values, clears the
// byte count and selects SHA-1.
module md5_sha1_hash_engine #(
	parameter int COUNT_WIDTH = msh_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data,       // algorithm
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // message_byte
	input  logic [0:0]  s_axis_tuser,   // has_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // digest_word
	output logic [2:0]  m_axis_tuser,   // word_index
	output logic        m_axis_tlast
);

	msh_pkg::state_t state_q, state_d;
	msh_pkg::ret_t   ret_q;
	logic                   alg_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [6:0]             rnd_q;
	logic [2:0]             oi_q;
	logic [31:0]            chain_q [5];
	logic [31:0]            w_q [5];
	logic [31:0]            blk_q [16];

	logic        in_acc, out_acc, last_word;
	logic [5:0]  pos, k;
	logic [3:0]  g;
	logic [31:0] f_md5, md5_sum, md5_rot, md5_new;
	logic [31:0] f_sha, c_sha, sha_t, sha_w;
	logic [4:0]  s;
	logic [63:0] bits;
	logic [6:0]  last_rnd;

	assign cfg_ready = (state_q == msh_pkg::ST_IDLE);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_acc   = m_axis_tvalid && m_axis_tready;
	assign cnt_inc   = cnt_q + COUNT_WIDTH'(1);
	assign pos       = cnt_q[5:0];
	assign bits      = 64'(cnt_q) << 3;
	assign last_rnd  = (alg_q == msh_pkg::ALG_SHA1) ? msh_pkg::SHA1_LAST_ROUND
		: msh_pkg::MD5_LAST_ROUND;
	assign last_word = oi_q == ((alg_q == msh_pkg::ALG_SHA1) ? msh_pkg::SHA1_LAST_WORD
		: msh_pkg::MD5_LAST_WORD);

	always_comb begin
		k = rnd_q[5:0];
		case (k[5:4])
			2'd0: begin
				f_md5 = (w_q[1] & w_q[2]) | (~w_q[1] & w_q[3]);
				g = k[3:0];
			end
			2'd1: begin
				f_md5 = (w_q[1] & w_q[3]) | (w_q[2] & ~w_q[3]);
				g = 4'(k * 6'd5 + 6'd1);
			end
			2'd2: begin
				f_md5 = w_q[1] ^ w_q[2] ^ w_q[3];
				g = 4'(k * 6'd3 + 6'd5);
			end
			default: begin
				f_md5 = w_q[2] ^ (w_q[1] | ~w_q[3]);
				g = 4'(k * 6'd7);
			end
		endcase
		s = msh_pkg::md5_s(k);
		md5_sum = w_q[0] + f_md5 + msh_pkg::md5_k(k) + msh_pkg::swap32(blk_q[g]);
		md5_rot = (md5_sum << s) | (md5_sum >> (6'd32 - {1'b0, s}));
		md5_new = w_q[1] + md5_rot;

		if (rnd_q < 7'd20) begin
			f_sha = (w_q[1] & w_q[2]) | (~w_q[1] & w_q[3]);
			c_sha = msh_pkg::SHA1_K0;
		end else if (rnd_q < 7'd40) begin
			f_sha = w_q[1] ^ w_q[2] ^ w_q[3];
			c_sha = msh_pkg::SHA1_K1;
		end else if (rnd_q < 7'd60) begin
			f_sha = (w_q[1] & w_q[2]) | (w_q[1] & w_q[3]) | (w_q[2] & w_q[3]);
			c_sha = msh_pkg::SHA1_K2;
		end else begin
			f_sha = w_q[1] ^ w_q[2] ^ w_q[3];
			c_sha = msh_pkg::SHA1_K3;
		end
		sha_t = {w_q[0][26:0], w_q[0][31:27]} + f_sha + w_q[4] + c_sha + blk_q[0];
		sha_w = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			msh_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser[0] && cnt_inc[5:0] == 6'd0) begin
						state_d = msh_pkg::ST_LOAD;
					end else if (s_axis_tlast) begin
						state_d = msh_pkg::ST_PAD;
					end
				end
			end
			msh_pkg::ST_LOAD: state_d = msh_pkg::ST_ROUND;
			msh_pkg::ST_ROUND: begin
				if (rnd_q == last_rnd) begin
					state_d = msh_pkg::ST_FOLD;
				end
			end
			msh_pkg::ST_FOLD: begin
				unique case (ret_q)
					msh_pkg::RET_IDLE: state_d = msh_pkg::ST_IDLE;
					msh_pkg::RET_PAD:  state_d = msh_pkg::ST_PAD;
					msh_pkg::RET_LEN:  state_d = msh_pkg::ST_LEN;
					default:           state_d = msh_pkg::ST_OUT;
				endcase
			end
			msh_pkg::ST_PAD: state_d = msh_pkg::ST_LOAD;
			msh_pkg::ST_LEN: state_d = msh_pkg::ST_LOAD;
			msh_pkg::ST_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready && last_word) begin
					state_d = msh_pkg::ST_IDLE;
				end
			end
			default: state_d = msh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q <= msh_pkg::ALG_SHA1;
			ret_q <= msh_pkg::RET_IDLE;
			cnt_q <= '0;
			rnd_q <= '0;
			oi_q <= '0;
			chain_q[0] <= msh_pkg::INIT_H0;
			chain_q[1] <= msh_pkg::INIT_H1;
			chain_q[2] <= msh_pkg::INIT_H2;
			chain_q[3] <= msh_pkg::INIT_H3;
			chain_q[4] <= msh_pkg::INIT_H4;
		end else begin
			if (cfg_valid && cfg_ready) begin
				alg_q <= cfg_data[0];
			end
			case (state_q)
				msh_pkg::ST_IDLE: begin
					if (in_acc && s_axis_tuser[0]) begin
						cnt_q <= cnt_inc;
						ret_q <= s_axis_tlast ? msh_pkg::RET_PAD : msh_pkg::RET_IDLE;
					end
				end
				msh_pkg::ST_LOAD: rnd_q <= '0;
				msh_pkg::ST_ROUND: rnd_q <= rnd_q + 7'd1;
				msh_pkg::ST_FOLD: begin
					for (int i = 0; i < 4; i++) begin
						chain_q[i] <= chain_q[i] + w_q[i];
					end
					if (alg_q == msh_pkg::ALG_SHA1) begin
						chain_q[4] <= chain_q[4] + w_q[4];
					end
				end
				msh_pkg::ST_PAD: begin
					ret_q <= (pos >= 6'd56) ? msh_pkg::RET_LEN : msh_pkg::RET_OUT;
				end
				msh_pkg::ST_LEN: ret_q <= msh_pkg::RET_OUT;
				msh_pkg::ST_OUT: begin
					if (out_acc) begin
						oi_q <= oi_q + 3'd1;
						if (last_word) begin
							oi_q <= '0;
							cnt_q <= '0;
							chain_q[0] <= msh_pkg::INIT_H0;
							chain_q[1] <= msh_pkg::INIT_H1;
							chain_q[2] <= msh_pkg::INIT_H2;
							chain_q[3] <= msh_pkg::INIT_H3;
							chain_q[4] <= msh_pkg::INIT_H4;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			msh_pkg::ST_IDLE: begin
				if (in_acc && s_axis_tuser[0]) begin
					blk_q[pos[5:2]][(5'd3 - {3'd0, pos[1:0]}) * 5'd8 +: 8] <= s_axis_tdata;
				end
			end
			msh_pkg::ST_LOAD: begin
				for (int i = 0; i < 5; i++) begin
					w_q[i] <= chain_q[i];
				end
			end
			msh_pkg::ST_ROUND: begin
				if (alg_q == msh_pkg::ALG_SHA1) begin
					w_q[0] <= sha_t;
					w_q[1] <= w_q[0];
					w_q[2] <= {w_q[1][1:0], w_q[1][31:2]};
					w_q[3] <= w_q[2];
					w_q[4] <= w_q[3];
					for (int i = 0; i < 15; i++) begin
						blk_q[i] <= blk_q[i + 1];
					end
					blk_q[15] <= {sha_w[30:0], sha_w[31]};
				end else begin
					w_q[0] <= w_q[3];
					w_q[1] <= md5_new;
					w_q[2] <= w_q[1];
					w_q[3] <= w_q[2];
				end
			end
			msh_pkg::ST_PAD: begin
				for (int i = 0; i < 64; i++) begin
					if (6'(i) == pos) begin
						blk_q[i / 4][(3 - (i % 4)) * 8 +: 8] <= msh_pkg::PAD_BYTE;
					end else if (6'(i) > pos) begin
						blk_q[i / 4][(3 - (i % 4)) * 8 +: 8] <= 8'h00;
					end
				end
				if (pos < 6'd56) begin
					if (alg_q == msh_pkg::ALG_SHA1) begin
						blk_q[14] <= bits[63:32];
						blk_q[15] <= bits[31:0];
					end else begin
						blk_q[14] <= msh_pkg::swap32(bits[31:0]);
						blk_q[15] <= msh_pkg::swap32(bits[63:32]);
					end
				end
			end
			msh_pkg::ST_LEN: begin
				for (int i = 0; i < 14; i++) begin
					blk_q[i] <= '0;
				end
				if (alg_q == msh_pkg::ALG_SHA1) begin
					blk_q[14] <= bits[63:32];
					blk_q[15] <= bits[31:0];
				end else begin
					blk_q[14] <= msh_pkg::swap32(bits[31:0]);
					blk_q[15] <= msh_pkg::swap32(bits[63:32]);
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tdata = (alg_q == msh_pkg::ALG_SHA1) ? chain_q[oi_q]
		: msh_pkg::swap32(chain_q[oi_q]);
	assign m_axis_tuser = oi_q;
	assign m_axis_tlast = last_word;

endmodule

// File: src/msh_checker.sv
// Port-level checker for the MD5/SHA-1 engine and its bind to the top level.
`timescale 1ns / 1ps

module msh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("Input accepted while a digest is presented.");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled digest word changed.");

	a_next_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
		else $error("Digest words are not consecutive.");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
		else $error("Engine did not return to idle after the final word.");

endmodule

bind md5_sha1_hash_engine msh_checker u_msh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// File: sim/tb_md5_sha1_hash_engine.sv
// Self-checking testbench of the MD5/SHA-1 hash engine with a built-in digest predictor.
`timescale 1ns / 1ps

module tb_md5_sha1_hash_engine;

	localparam int CW = 16;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_t;

	typedef struct {
		logic        alg;
		logic [7:0]  data;
		logic        has;
		logic        eom;
		logic        known;
		logic [31:0] words [5];
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	md5_sha1_hash_engine #(.COUNT_WIDTH(CW)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [31:0] md5_add [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	logic [4:0] rot_amt [16] = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

	logic          hash_alg;
	logic [31:0]   chain [5];
	logic [31:0]   blk [16];
	logic [CW-1:0] msg_bytes;
	digest_t       fresh_q [$];
	digest_t       digest_q [$];
	int            fails = 0;
	bit            snd_idle = 1'b1;
	bit            rcv_idle = 1'b1;
	int            items = 0;

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		logic [63:0] t;
		t = {x, x} << n;
		return t[63:32];
	endfunction

	function automatic logic [31:0] byte_rev(logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic void compress_block();
		logic [31:0] w [5];
		logic [31:0] sched [80];
		logic [31:0] f, c, t;
		int g, r;
		for (int i = 0; i < 5; i++) w[i] = chain[i];
		if (hash_alg == msh_pkg::ALG_MD5) begin
			for (int k = 0; k < 64; k++) begin
				r = k / 16;
				case (r)
					0: begin f = (w[1] & w[2]) | (~w[1] & w[3]); g = k; end
					1: begin f = (w[1] & w[3]) | (w[2] & ~w[3]); g = (5 * k + 1) % 16; end
					2: begin f = w[1] ^ w[2] ^ w[3]; g = (3 * k + 5) % 16; end
					default: begin f = w[2] ^ (w[1] | ~w[3]); g = (7 * k) % 16; end
				endcase
				t = w[3];
				w[3] = w[2];
				w[2] = w[1];
				w[1] = w[1] + rol(w[0] + f + md5_add[k] + byte_rev(blk[g]),
					rot_amt[r * 4 + k % 4]);
				w[0] = t;
			end
			for (int i = 0; i < 4; i++) chain[i] += w[i];
		end else begin
			for (int k = 0; k < 80; k++)
				sched[k] = (k < 16) ? blk[k] : rol(sched[k-3] ^ sched[k-8] ^ sched[k-14]
					^ sched[k-16], 1);
			for (int k = 0; k < 80; k++) begin
				if (k < 20) begin
					f = (w[1] & w[2]) | (~w[1] & w[3]);
					c = msh_pkg::SHA1_K0;
				end else if (k < 40) begin
					f = w[1] ^ w[2] ^ w[3];
					c = msh_pkg::SHA1_K1;
				end else if (k < 60) begin
					f = (w[1] & w[2]) | (w[1] & w[3]) | (w[2] & w[3]);
					c = msh_pkg::SHA1_K2;
				end else begin
					f = w[1] ^ w[2] ^ w[3];
					c = msh_pkg::SHA1_K3;
				end
				t = rol(w[0], 5) + f + w[4] + c + sched[k];
				w[4] = w[3];
				w[3] = w[2];
				w[2] = rol(w[1], 30);
				w[1] = w[0];
				w[0] = t;
			end
			for (int i = 0; i < 5; i++) chain[i] += w[i];
		end
	endfunction

	function automatic void put_byte(int pos, logic [7:0] b);
		int sh;
		sh = (3 - pos % 4) * 8;
		blk[pos / 4] = (blk[pos / 4] & ~(32'hff << sh)) | (32'(b) << sh);
	endfunction

	function automatic void restart_message();
		chain = '{msh_pkg::INIT_H0, msh_pkg::INIT_H1, msh_pkg::INIT_H2, msh_pkg::INIT_H3,
			msh_pkg::INIT_H4};
		for (int i = 0; i < 16; i++) blk[i] = '0;
		msg_bytes = '0;
	endfunction

	// Updates the running hash with one request and leaves any digest words in fresh_q.
	function automatic void hash_request(logic [7:0] b, logic has, logic eom);
		int pos, n;
		logic [63:0] bits;
		digest_t d;
		fresh_q.delete();
		if (has) begin
			put_byte(msg_bytes[5:0], b);
			msg_bytes++;
			if (msg_bytes[5:0] == 0) compress_block();
		end
		if (!eom) return;
		pos = msg_bytes[5:0];
		put_byte(pos, msh_pkg::PAD_BYTE);
		for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
		if (pos >= 56) begin
			compress_block();
			for (int i = 0; i < 16; i++) blk[i] = '0;
		end
		bits = 64'(msg_bytes) << 3;
		if (hash_alg == msh_pkg::ALG_MD5) begin
			blk[14] = byte_rev(bits[31:0]);
			blk[15] = byte_rev(bits[63:32]);
		end else begin
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
		end
		compress_block();
		n = (hash_alg == msh_pkg::ALG_MD5) ? 4 : 5;
		for (int i = 0; i < n; i++) begin
			d.word = (hash_alg == msh_pkg::ALG_MD5) ? byte_rev(chain[i]) : chain[i];
			d.idx = 3'(i);
			d.last = (i == n - 1);
			fresh_q.push_back(d);
		end
		restart_message();
	endfunction

	task automatic send_request(logic [7:0] b, logic has, logic eom);
		int gap;
		if (snd_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= has;
		s_axis_tlast <= eom;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items++;
		hash_request(b, has, eom);
		foreach (fresh_q[i]) digest_q.push_back(fresh_q[i]);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
		// A compression can still be running after a request without a digest.
		repeat (200) @(posedge clk);
	endtask

	task automatic write_algorithm(logic a);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= a;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		hash_alg = a;
	endtask

	task automatic send_message(int len, bit allow_switch);
		logic eom_has;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) send_request(8'($urandom), 1'b0, 1'b0);
			if (allow_switch && i == 70 && $urandom_range(0, 2) == 0)
				write_algorithm(~hash_alg);
			send_request(8'($urandom), 1'b1, 1'b0);
		end
		eom_has = $urandom_range(0, 1);
		send_request(8'($urandom), eom_has, 1'b1);
	endtask

	function automatic int pick_length();
		int lens [8] = '{55, 56, 63, 64, 65, 119, 120, 128};
		return ($urandom_range(0, 2) == 0) ? lens[$urandom_range(0, 7)] : $urandom_range(0, 20);
	endfunction

	always @(posedge clk) begin
		digest_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (digest_q.size() == 0) begin
				$error("digest word %h arrived with none expected", m_axis_tdata);
				fails++;
			end else begin
				e = digest_q.pop_front();
				if (m_axis_tdata !== e.word) begin
					$error("digest_word expected %h actual %h", e.word, m_axis_tdata);
					fails++;
				end
				if (m_axis_tuser !== e.idx) begin
					$error("word_index expected %0d actual %0d", e.idx, m_axis_tuser);
					fails++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_word expected %0d actual %0d", e.last, m_axis_tlast);
					fails++;
				end
			end
		end
	end

	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if (rcv_idle && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 13) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("tb_md5_sha1_hash_engine failed");
		$finish;
	end

	row_t rows [$];

	function automatic void add_row(logic alg, logic [7:0] b, logic has, logic eom,
		logic known = 1'b0, logic [31:0] w0 = 0, logic [31:0] w1 = 0,
		logic [31:0] w2 = 0, logic [31:0] w3 = 0, logic [31:0] w4 = 0);
		row_t r;
		r.alg = alg;
		r.data = b;
		r.has = has;
		r.eom = eom;
		r.known = known;
		r.words = '{w0, w1, w2, w3, w4};
		rows.push_back(r);
	endfunction

	initial begin
		digest_t d;
		int n;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		s_axis_tlast <= 1'b0;
		hash_alg = msh_pkg::ALG_SHA1;
		restart_message();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		add_row(msh_pkg::ALG_SHA1, 8'h00, 1'b0, 1'b0);
		add_row(msh_pkg::ALG_SHA1, 8'h00, 1'b0, 1'b1, 1'b1, 32'hda39a3ee, 32'h5e6b4b0d,
			32'h3255bfef, 32'h95601890, 32'hafd80709);
		add_row(msh_pkg::ALG_SHA1, "a", 1'b1, 1'b0);
		add_row(msh_pkg::ALG_SHA1, "b", 1'b1, 1'b0);
		add_row(msh_pkg::ALG_SHA1, 8'h00, 1'b0, 1'b0);
		add_row(msh_pkg::ALG_SHA1, "c", 1'b1, 1'b1, 1'b1, 32'ha9993e36, 32'h4706816a,
			32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d);
		add_row(msh_pkg::ALG_SHA1, 8'hff, 1'b1, 1'b0);
		add_row(msh_pkg::ALG_SHA1, 8'h00, 1'b1, 1'b1);
		add_row(msh_pkg::ALG_MD5, 8'h00, 1'b0, 1'b1, 1'b1, 32'hd41d8cd9, 32'h8f00b204,
			32'he9800998, 32'hecf8427e);
		add_row(msh_pkg::ALG_MD5, "a", 1'b1, 1'b0);
		add_row(msh_pkg::ALG_MD5, "b", 1'b1, 1'b0);
		add_row(msh_pkg::ALG_MD5, "c", 1'b1, 1'b1, 1'b1, 32'h90015098, 32'h3cd24fb0,
			32'hd6963f7d, 32'h28e17f72);
		add_row(msh_pkg::ALG_MD5, 8'h00, 1'b1, 1'b0);
		add_row(msh_pkg::ALG_MD5, 8'hff, 1'b1, 1'b0);
		add_row(msh_pkg::ALG_MD5, 8'h55, 1'b1, 1'b0);
		add_row(msh_pkg::ALG_MD5, 8'h00, 1'b0, 1'b0);
		add_row(msh_pkg::ALG_MD5, 8'haa, 1'b1, 1'b1);
		add_row(msh_pkg::ALG_MD5, 8'hff, 1'b0, 1'b1);

		foreach (rows[i]) begin
			if (rows[i].alg != hash_alg) write_algorithm(rows[i].alg);
			send_request(rows[i].data, rows[i].has, rows[i].eom);
			if (rows[i].known) begin
				repeat (fresh_q.size()) void'(digest_q.pop_back());
				n = (rows[i].alg == msh_pkg::ALG_MD5) ? 4 : 5;
				for (int k = 0; k < n; k++) begin
					d.word = rows[i].words[k];
					d.idx = 3'(k);
					d.last = (k == n - 1);
					digest_q.push_back(d);
				end
			end
		end

		while (items < 130) begin
			if ($urandom_range(0, 3) == 0) write_algorithm(~hash_alg);
			send_message(pick_length(), 1'b1);
		end

		wait_drained();
		snd_idle = 1'b0;
		rcv_idle = 1'b0;
		write_algorithm(msh_pkg::ALG_MD5);
		send_message(pick_length(), 1'b0);
		write_algorithm(msh_pkg::ALG_SHA1);
		send_message(pick_length(), 1'b0);

		wait_drained();
		if (fails == 0) begin
			$display("tb_md5_sha1_hash_engine passed");
		end else begin
			$display("tb_md5_sha1_hash_engine failed");
		end
		$finish;
	end

endmodule
